### rtl/vbd_pkg.sv
// ----------------------------------------------------------------------------
// vbd_pkg: shared types and constants of the video bus decoder
// Beat payloads, mirroring modes, address regions and store geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package vbd_pkg;

  // store geometry
  localparam int unsigned BANK_BYTES    = 1024;
  localparam int unsigned NT_DEPTH      = 2 * BANK_BYTES;
  localparam int unsigned NT_ADDR_W     = $clog2(NT_DEPTH);
  localparam int unsigned BANK_OFS_W    = $clog2(BANK_BYTES);
  localparam int unsigned PALETTE_BYTES = 32;
  localparam int unsigned PAL_ADDR_W    = $clog2(PALETTE_BYTES);

  // access kind codes
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [1:0] {
    MIRROR_HORIZONTAL = 2'd0,
    MIRROR_VERTICAL   = 2'd1,
    MIRROR_SINGLE_LO  = 2'd2,
    MIRROR_SINGLE_HI  = 2'd3
  } mirror_mode_e;

  typedef enum logic [1:0] {
    REGION_CART      = 2'd0,
    REGION_NAMETABLE = 2'd1,
    REGION_PALETTE   = 2'd2,
    REGION_HIGH      = 2'd3
  } region_e;

  // source of the returned byte
  typedef enum logic [1:0] {
    RD_ZERO      = 2'd0,
    RD_CART      = 2'd1,
    RD_NAMETABLE = 2'd2,
    RD_PALETTE   = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [7:0]  cartridge_byte;
  } vbd_req_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        cartridge_access;
    logic        cartridge_write;
    logic [12:0] cartridge_address;
    logic        out_of_range;
  } vbd_rsp_t;

  // decoded access, handed from the decoder to the top level
  typedef struct packed {
    region_e                 region;
    logic                    is_write;
    logic [NT_ADDR_W-1:0]    nt_addr;
    logic [PAL_ADDR_W-1:0]   pal_addr;
  } vbd_dec_t;

endpackage

`default_nettype wire

### rtl/vbd_stream_if.sv
// ----------------------------------------------------------------------------
// vbd_stream_if: valid/ready channel
// Carries one payload beat per handshake; the payload type is a parameter.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/vbd_ram.sv
// ----------------------------------------------------------------------------
// vbd_ram: single-port RAM with registered read
// One access per cycle when enabled: a write, or a read into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // storage array and read register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/vbd_palette.sv
// ----------------------------------------------------------------------------
// vbd_palette: palette register file
// 32 bytes in flops cleared at reset, one write or one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vbd_palette
  import vbd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  we_i,
  input  wire logic [PAL_ADDR_W-1:0] addr_i,
  input  wire logic [7:0]            wdata_i,
  output logic      [7:0]            rdata_o
);

  logic [7:0] pal_q [PALETTE_BYTES];
  logic [7:0] rdata_q;

  // palette entries, zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_BYTES; i++) begin
        pal_q[i] <= 8'h00;
      end
    end else if (en_i && we_i) begin
      pal_q[addr_i] <= wdata_i;
    end
  end

  // read register
  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= pal_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/vbd_addr_decode.sv
// ----------------------------------------------------------------------------
// vbd_addr_decode: video bus address decoder
// Classifies an access by region and forms the nametable and palette indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module vbd_addr_decode
  import vbd_pkg::*;
(
  input  wire vbd_req_t     req_i,
  input  wire mirror_mode_e mode_i,
  output vbd_dec_t          dec_o
);

  logic [15:0]           addr;
  logic                  bank;
  logic [PAL_ADDR_W-1:0] pal_raw;
  region_e               region;
  logic [PAL_ADDR_W-1:0] pal_addr;

  assign addr    = req_i.bus_address;
  assign pal_raw = addr[PAL_ADDR_W-1:0];

  // region select
  always_comb begin
    if (addr[15:13] == 3'b000) begin
      region = REGION_CART;
    end else if (addr[15:14] != 2'b00) begin
      region = REGION_HIGH;
    end else if (addr[13:8] == 6'h3f) begin
      region = REGION_PALETTE;
    end else begin
      region = REGION_NAMETABLE;
    end
  end

  // bank from the mirroring mode
  always_comb begin
    unique case (mode_i)
      MIRROR_HORIZONTAL: bank = addr[11];
      MIRROR_VERTICAL:   bank = addr[10];
      MIRROR_SINGLE_LO:  bank = 1'b0;
      MIRROR_SINGLE_HI:  bank = 1'b1;
      default:           bank = 1'b0;
    endcase
  end

  // backdrop entries of the sprite palettes fold onto the background ones
  always_comb begin
    pal_addr = pal_raw;
    if (pal_raw[4] && (pal_raw[1:0] == 2'b00)) begin
      pal_addr[4] = 1'b0;
    end
  end

  assign dec_o = '{
    region:   region,
    is_write: (req_i.kind == KIND_WRITE),
    nt_addr:  {bank, addr[BANK_OFS_W-1:0]},
    pal_addr: pal_addr
  };

endmodule

`default_nettype wire

### rtl/video_bus_decoder_with_mirroring.sv
// ----------------------------------------------------------------------------
// video_bus_decoder_with_mirroring: video bus decoder with nametable mirroring
// Decodes cartridge, nametable and palette accesses of the video bus.
// ----------------------------------------------------------------------------
// req_i carries one bus access per beat (kind, address, write byte and the
// byte the cartridge drives for a pattern-table read). rsp_o returns one
// result beat per access, in order. cfg_i writes the mirroring mode; it is
// always ready, and the user must write it only while no access is in
// flight; the block itself does not enforce this. An access is taken into
// an input register, decoded there, and the store access happens as it
// moves into the result register. While the receiver takes results and the
// clearing sweep is done, one access is taken every cycle; the single-port
// nametable RAM sees at most one read or write per cycle. After reset the
// nametable RAM is swept to zero, one entry per cycle; during the sweep
// req_i.ready stays low. The palette and the mirroring mode clear at once.
// When the receiver stalls, the result register holds and the input
// register, if empty, still takes one more beat before req_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module video_bus_decoder_with_mirroring
  import vbd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  vbd_stream_if.sink   req_i,
  vbd_stream_if.source rsp_o,
  vbd_stream_if.sink   cfg_i
);

  mirror_mode_e         mode_q;
  logic                 clr_busy_q;
  logic [NT_ADDR_W-1:0] clr_addr_q;
  logic                 s1_valid_q;
  vbd_req_t             s1_req_q;
  logic                 out_valid_q;
  vbd_rsp_t             out_rsp_q;
  rd_sel_e              rd_sel_q;
  logic [7:0]           cart_byte_q;

  vbd_dec_t             dec;
  logic                 advance;
  logic                 fire;
  logic                 nt_en;
  logic                 nt_we;
  logic [NT_ADDR_W-1:0] nt_addr;
  logic [7:0]           nt_wdata;
  logic [7:0]           nt_rdata;
  logic                 pal_en;
  logic [7:0]           pal_rdata;
  vbd_rsp_t             rsp_d;
  rd_sel_e              rd_sel_d;

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIRROR_HORIZONTAL;
    end else if (cfg_i.valid) begin
      mode_q <= mirror_mode_e'(cfg_i.data[1:0]);
    end
  end

  // nametable clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // pipeline flow control
  assign advance     = !out_valid_q || rsp_o.ready;
  assign fire        = s1_valid_q && advance;
  assign req_i.ready = !clr_busy_q && (!s1_valid_q || advance);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_req_q <= req_i.data;
    end
  end

  vbd_addr_decode u_decode (
    .req_i  (s1_req_q),
    .mode_i (mode_q),
    .dec_o  (dec)
  );

  // nametable RAM port: sweep while clearing, otherwise the decoded access
  assign nt_en    = clr_busy_q || (fire && (dec.region == REGION_NAMETABLE));
  assign nt_we    = clr_busy_q || dec.is_write;
  assign nt_addr  = clr_busy_q ? clr_addr_q : dec.nt_addr;
  assign nt_wdata = clr_busy_q ? 8'h00 : s1_req_q.write_byte;

  vbd_ram #(
    .WIDTH (8),
    .DEPTH (NT_DEPTH)
  ) u_nametable (
    .clk_i   (clk_i),
    .en_i    (nt_en),
    .we_i    (nt_we),
    .addr_i  (nt_addr),
    .wdata_i (nt_wdata),
    .rdata_o (nt_rdata)
  );

  assign pal_en = fire && (dec.region == REGION_PALETTE);

  vbd_palette u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pal_en),
    .we_i    (dec.is_write),
    .addr_i  (dec.pal_addr),
    .wdata_i (s1_req_q.write_byte),
    .rdata_o (pal_rdata)
  );

  // result fields other than the store data
  always_comb begin
    rsp_d                   = '0;
    rd_sel_d                = RD_ZERO;
    case (dec.region)
      REGION_CART: begin
        rsp_d.cartridge_access  = 1'b1;
        rsp_d.cartridge_write   = dec.is_write;
        rsp_d.cartridge_address = s1_req_q.bus_address[12:0];
        rd_sel_d                = dec.is_write ? RD_ZERO : RD_CART;
      end
      REGION_NAMETABLE: begin
        rd_sel_d = dec.is_write ? RD_ZERO : RD_NAMETABLE;
      end
      REGION_PALETTE: begin
        rd_sel_d = dec.is_write ? RD_ZERO : RD_PALETTE;
      end
      default: begin
        rsp_d.out_of_range = !dec.is_write;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rsp_q   <= rsp_d;
      rd_sel_q    <= rd_sel_d;
      cart_byte_q <= s1_req_q.cartridge_byte;
    end
  end

  // returned byte from the selected source
  always_comb begin
    rsp_o.data = out_rsp_q;
    unique case (rd_sel_q)
      RD_ZERO:      rsp_o.data.read_byte = 8'h00;
      RD_CART:      rsp_o.data.read_byte = cart_byte_q;
      RD_NAMETABLE: rsp_o.data.read_byte = nt_rdata;
      RD_PALETTE:   rsp_o.data.read_byte = pal_rdata;
      default:      rsp_o.data.read_byte = 8'h00;
    endcase
  end

  assign rsp_o.valid = out_valid_q;

endmodule

`default_nettype wire
